/* rtl/core/cdf97_pkg.sv */
package cdf97_pkg;

	// width of the length register and of the effective block length
	localparam int LEN_W = 7;
	localparam int DATA_W = 24;
	localparam int COEF_W = 18;

	// lifting constants and scale factors, Q2.16
	localparam logic signed [COEF_W-1:0] C_P1 = -18'sd103949;
	localparam logic signed [COEF_W-1:0] C_U1 = -18'sd3472;
	localparam logic signed [COEF_W-1:0] C_P2 = 18'sd57862;
	localparam logic signed [COEF_W-1:0] C_U2 = 18'sd29066;
	localparam logic signed [COEF_W-1:0] C_K = 18'sd75340;
	localparam logic signed [COEF_W-1:0] C_INVK = 18'sd57007;

	localparam logic [2:0] PASS_LAST = 3'd4;

	// register indexes on the configuration port
	localparam logic REG_LENGTH = 1'b0;
	localparam logic REG_DIRECTION = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_NB,
		ST_SELF,
		ST_MUL,
		ST_WB,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

	// one pass over the buffer: scaling, or lifting on one parity
	typedef struct packed {
		logic scale;
		logic odd;
		logic [COEF_W-1:0] coef;
	} pass_t;

	typedef struct packed {
		logic load_wr;
		logic rd_nb;
		logic rd_self;
		logic mul;
		logic wb;
		logic scale;
		logic [COEF_W-1:0] coef;
		logic emit_rd;
		logic emit_ld;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

	function automatic pass_t pass_info(input logic dir, input logic [2:0] pass);
		pass_t p;
		p.scale = 1'b0;
		p.odd = 1'b0;
		p.coef = '0;
		if (!dir) begin
			case (pass)
				3'd0: begin p.odd = 1'b1; p.coef = C_P1; end
				3'd1: begin p.odd = 1'b0; p.coef = C_U1; end
				3'd2: begin p.odd = 1'b1; p.coef = C_P2; end
				3'd3: begin p.odd = 1'b0; p.coef = C_U2; end
				default: p.scale = 1'b1;
			endcase
		end else begin
			case (pass)
				3'd0: p.scale = 1'b1;
				3'd1: begin p.odd = 1'b0; p.coef = -C_U2; end
				3'd2: begin p.odd = 1'b1; p.coef = -C_P2; end
				3'd3: begin p.odd = 1'b0; p.coef = -C_U1; end
				default: begin p.odd = 1'b1; p.coef = -C_P1; end
			endcase
		end
		return p;
	endfunction

	// forward: odd by 1/K, even by K; inverse the other way round
	function automatic logic [COEF_W-1:0] scale_coef(input logic dir, input logic odd);
		return (dir ^ odd) ? C_INVK : C_K;
	endfunction

endpackage

/* rtl/core/cdf97_dp.sv */
module cdf97_dp
	import cdf97_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	input  logic [$clog2(MAX_LEN)-1:0] idx,
	input  logic [LEN_W-1:0] n,
	input  logic dir,
	input  logic signed [DATA_W-1:0] sample,
	input  logic out_ready,
	output logic out_valid,
	output logic signed [DATA_W-1:0] coefficient,
	output logic last,
	output dp_stat_t stat
);

	localparam int AW = $clog2(MAX_LEN);

	logic signed [DATA_W-1:0] mem_q [MAX_LEN];
	logic signed [DATA_W-1:0] rd_a_q, rd_b_q, self_q;
	logic signed [DATA_W:0] sum_q, mul_op;
	logic signed [DATA_W+COEF_W:0] prod_q, prod_r;
	logic signed [26:0] rnd;
	logic signed [27:0] tot;
	logic signed [DATA_W-1:0] wb_val, wdata;
	logic signed [DATA_W-1:0] coef_q;
	logic last_q, out_valid_q;

	logic [LEN_W-1:0] h;
	logic k_ge;
	logic [AW-1:0] base, perm, left, right, n_m1, n_m2, waddr, raddr_a;
	logic we, rd_a_en;

	// interleave map: first half to even slots, second half to odd slots
	always_comb begin
		h = n >> 1;
		k_ge = LEN_W'(idx) >= h;
		base = k_ge ? idx - AW'(h) : idx;
		perm = {base[AW-2:0], k_ge};
		n_m1 = AW'(n - LEN_W'(1));
		n_m2 = AW'(n - LEN_W'(2));
		left = (idx == '0) ? AW'(1) : idx - AW'(1);
		right = (idx == n_m1) ? n_m2 : idx + AW'(1);
	end

	always_comb begin
		we = cmd.load_wr | cmd.wb;
		waddr = (cmd.load_wr && dir) ? perm : idx;
		wdata = cmd.load_wr ? sample : wb_val;
		rd_a_en = cmd.rd_nb | cmd.rd_self | cmd.emit_rd;
		if (cmd.rd_nb) begin
			raddr_a = left;
		end else if (cmd.emit_rd) begin
			raddr_a = dir ? idx : perm;
		end else begin
			raddr_a = idx;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= mem_q[raddr_a];
		end
		if (cmd.rd_nb) begin
			rd_b_q <= mem_q[right];
		end
	end

	assign mul_op = cmd.scale ? {rd_a_q[DATA_W-1], rd_a_q} : sum_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_self) begin
			sum_q <= {rd_a_q[DATA_W-1], rd_a_q} + {rd_b_q[DATA_W-1], rd_b_q};
		end
		if (cmd.mul) begin
			prod_q <= mul_op * $signed(cmd.coef);
			self_q <= cmd.scale ? '0 : rd_a_q;
		end
	end

	// round half up, add, saturate to 24 bits
	always_comb begin
		prod_r = prod_q + 43'sd32768;
		rnd = prod_r[42:16];
		tot = {{4{self_q[DATA_W-1]}}, self_q} + {rnd[26], rnd};
		if (tot > 28'sd8388607) begin
			wb_val = 24'sh7FFFFF;
		end else if (tot < -28'sd8388608) begin
			wb_val = 24'sh800000;
		end else begin
			wb_val = tot[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			coef_q <= rd_a_q;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign coefficient = coef_q;
	assign last = last_q;
	assign stat.out_full = out_valid_q & ~out_ready;

endmodule

/* rtl/core/cdf97_ctrl.sv */
module cdf97_ctrl
	import cdf97_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic cfg_clr,
	input  logic dir,
	input  logic [LEN_W-1:0] n,
	input  dp_stat_t stat,
	output logic in_ready,
	output dp_cmd_t cmd,
	output logic [$clog2(MAX_LEN)-1:0] idx
);

	localparam int AW = $clog2(MAX_LEN);

	state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [2:0] pass_q, pass_d;
	pass_t pi, pi_nx, pi_0;
	logic last_elem, pass_end;

	always_comb begin
		pi = pass_info(dir, pass_q);
		pi_nx = pass_info(dir, pass_q + 3'd1);
		pi_0 = pass_info(dir, 3'd0);
		last_elem = LEN_W'(idx_q) == (n - LEN_W'(1));
		pass_end = (LEN_W'(idx_q) + (pi.scale ? LEN_W'(1) : LEN_W'(2))) >= n;
	end

	// next state and counters
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pass_d = pass_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					if (last_elem) begin
						pass_d = 3'd0;
						idx_d = AW'(pi_0.odd);
						state_d = pi_0.scale ? ST_SELF : ST_NB;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			ST_NB: state_d = ST_SELF;
			ST_SELF: state_d = ST_MUL;
			ST_MUL: state_d = ST_WB;
			ST_WB: begin
				if (pass_end) begin
					if (pass_q == PASS_LAST) begin
						idx_d = '0;
						state_d = ST_EM_RD;
					end else begin
						pass_d = pass_q + 3'd1;
						idx_d = AW'(pi_nx.odd);
						state_d = pi_nx.scale ? ST_SELF : ST_NB;
					end
				end else begin
					idx_d = idx_q + (pi.scale ? AW'(1) : AW'(2));
					state_d = pi.scale ? ST_SELF : ST_NB;
				end
			end
			ST_EM_RD: state_d = ST_EM_LD;
			ST_EM_LD: begin
				if (!stat.out_full) begin
					if (last_elem) begin
						idx_d = '0;
						state_d = ST_LOAD;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
		if (cfg_clr) begin
			idx_d = '0;
		end
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		idx = idx_q;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load_wr = in_valid;
			end
			ST_NB: cmd.rd_nb = 1'b1;
			ST_SELF: cmd.rd_self = 1'b1;
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.scale = pi.scale;
				cmd.coef = pi.scale ? scale_coef(dir, idx_q[0]) : pi.coef;
			end
			ST_WB: cmd.wb = 1'b1;
			ST_EM_RD: cmd.emit_rd = 1'b1;
			ST_EM_LD: begin
				if (!stat.out_full) begin
					cmd.emit_ld = 1'b1;
					cmd.last = last_elem;
					if (!last_elem) begin
						cmd.emit_rd = 1'b1;
						idx = idx_q + AW'(1);
					end
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q <= '0;
			pass_q <= 3'd0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pass_q <= pass_d;
		end
	end

endmodule

/* rtl/core/cdf97_lifting_wavelet_top.sv */
// a block is loaded, transformed and emitted before the next block is taken in
// the transform time is set by the single multiplier and the two-read-port buffer:
// a lifted element goes neighbour read, self read, multiply, write back; a scaled one skips the neighbour read
// reset (arst_n, asynchronous, active low): length 64, forward, empty block, no result pending
module cdf97_lifting_wavelet_top
	import cdf97_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	// sample channel
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [DATA_W-1:0] sample,
	// coefficient channel
	output logic out_valid,
	input  logic out_ready,
	output logic signed [DATA_W-1:0] coefficient,
	output logic last,
	// register port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam logic [LEN_W-1:0] MAX_EVEN = LEN_W'(MAX_LEN) & ~LEN_W'(1);

	logic [LEN_W-1:0] length_q;
	logic direction_q;
	logic cfg_wr;
	logic [LEN_W-1:0] len_even, n;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [$clog2(MAX_LEN)-1:0] idx;

	// register file: length at 0x0, direction at 0x4
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_W'(64);
			direction_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LENGTH: length_q <= pwdata[LEN_W-1:0];
				REG_DIRECTION: direction_q <= pwdata[0];
				default: length_q <= length_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LENGTH: prdata = {{(32-LEN_W){1'b0}}, length_q};
			REG_DIRECTION: prdata = {31'b0, direction_q};
			default: prdata = '0;
		endcase
	end

	// effective block length: even, clamped to 4..MAX_LEN
	always_comb begin
		len_even = {length_q[LEN_W-1:1], 1'b0};
		if (len_even < LEN_W'(4)) begin
			n = LEN_W'(4);
		end else if (len_even > MAX_EVEN) begin
			n = MAX_EVEN;
		end else begin
			n = len_even;
		end
	end

	// sequencer: load, lifting passes and scaling over the buffer, emit
	// any register write restarts the block being loaded
	cdf97_ctrl #(
		.MAX_LEN(MAX_LEN)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.cfg_clr(cfg_wr),
		.dir(direction_q),
		.n(n),
		.stat(stat),
		.in_ready(in_ready),
		.cmd(cmd),
		.idx(idx)
	);

	// buffer memory, multiply-round-saturate unit and output register
	cdf97_dp #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.idx(idx),
		.n(n),
		.dir(direction_q),
		.sample(sample),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.coefficient(coefficient),
		.last(last),
		.stat(stat)
	);

	// an element update always goes read-self, multiply, write back
	a_mul_after_self: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> $past(cmd.rd_self))
		else $error("multiply without preceding self read");

	a_wb_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> $past(cmd.mul))
		else $error("write back without preceding multiply");

	// a result is never loaded over one still waiting for its request to complete
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> !(out_valid && !out_ready))
		else $error("output register overwritten");

	// after the final result of a block the next block can load at once
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld && cmd.last |=> in_ready)
		else $error("not ready for next block");

endmodule
